// ===== src/puvf_pkg.sv =====
// puvf_pkg: shared types, constants and helpers of the particle uv flicker offset core
// used by puvf_sine and particle_uv_flicker_offset_core; no dependencies
package puvf_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_AMPLITUDE_X = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE_Y = 3'd1;
    localparam logic [2:0] REG_FREQUENCY_X = 3'd2;
    localparam logic [2:0] REG_FREQUENCY_Y = 3'd3;
    localparam logic [2:0] REG_DRIFT_X     = 3'd4;
    localparam logic [2:0] REG_DRIFT_Y     = 3'd5;
    localparam logic [2:0] REG_IRREGULAR   = 3'd6;

    // multiplicative hash and secondary angle scale factors
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam logic [17:0] A2_TIME_K  = 18'd155320;
    localparam logic [16:0] A2_SEED_K  = 17'd111411;
    localparam logic [17:0] ONE_Q16    = 18'd65536;

    // odd polynomial sine coefficients, q16
    localparam logic [16:0] SIN_C1 = 17'd102939;
    localparam logic [15:0] SIN_C3 = 16'd42155;
    localparam logic [12:0] SIN_C5 = 13'd4765;

    localparam int DIV_BITS = 16;

    // floor a q.32 value to q16.16 and saturate to 32 bits
    function automatic logic [31:0] sat_q16(input logic signed [57:0] v);
        logic signed [41:0] q;
        logic [31:0]        r;
        q = 42'(v >>> 16);
        if (q > 42'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (q < -42'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/puvf_sine.sv =====
// puvf_sine: four stage polynomial sine of a q0.16 turn angle, q1.15 result
// depends on puvf_pkg for the coefficients
module puvf_sine #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sine
);

    localparam int SHIFT = 16 - SINE_TABLE_BITS;

    logic [15:0] angle_q;
    logic [16:0] z_fold;
    logic [33:0] zz;
    logic [29:0] p2;
    logic [32:0] p3;
    logic [33:0] p4;
    logic [16:0] s_mag;
    logic [14:0] s_clamp;

    logic [16:0] r_z1, r_z2_1;
    logic [1:0]  r_q1;
    logic [16:0] r_z2, r_zz2;
    logic [15:0] r_r1;
    logic [1:0]  r_q2;
    logic [16:0] r_z3;
    logic [16:0] r_r3;
    logic [1:0]  r_q3;
    logic signed [15:0] r_sine;

    always_comb begin
        angle_q = (i_angle >> SHIFT) << SHIFT;
        z_fold  = {1'b0, angle_q[13:0], 2'b00};
        if (angle_q[14]) begin
            z_fold = 17'd65536 - z_fold;
        end
        zz      = z_fold * z_fold;
        p2      = puvf_pkg::SIN_C5 * r_z2_1;
        p3      = r_zz2 * r_r1;
        p4      = r_z3 * r_r3;
        s_mag   = p4[33:17];
        s_clamp = (s_mag > 17'd32767) ? 15'h7fff : s_mag[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= z_fold;
            r_z2_1 <= zz[32:16];
            r_q1   <= angle_q[15:14];
            r_z2   <= r_z1;
            r_zz2  <= r_z2_1;
            r_r1   <= puvf_pkg::SIN_C3 - p2[29:16];
            r_q2   <= r_q1;
            r_z3   <= r_z2;
            r_r3   <= puvf_pkg::SIN_C1 - p3[32:16];
            r_q3   <= r_q2;
            r_sine <= r_q3[1] ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});
        end
    end

    assign o_sine = r_sine;

endmodule

// ===== src/particle_uv_flicker_offset_core.sv =====
// particle_uv_flicker_offset_core: one transaction accepted per cycle while the output is not stalled.
// the whole pipeline advances together; a stalled output freezes every stage.
// stages: products and hash, seed and angles, three sine units of 4 stages,
// numerator, a 16 stage restoring divider for the vertical wobble, scaling and saturation.
// synchronous active low reset clears the valid bits and all configuration registers to 0.
// depends on puvf_pkg and puvf_sine
module particle_uv_flicker_offset_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_particle_index,
    input  logic [15:0]        i_phase_turns,
    input  logic [31:0]        i_time_q16,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_uv_offset_x,
    output logic signed [31:0] o_uv_offset_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int DEPTH  = 29;
    localparam int DB     = puvf_pkg::DIV_BITS;
    localparam int BASE_D = 8;

    logic [16:0]        r_amplitude_x, r_amplitude_y, r_irregularity;
    logic [13:0]        r_frequency_x, r_frequency_y;
    logic signed [23:0] r_drift_x, r_drift_y;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic [17:0]      div_den;

    // stage 1
    logic [31:0] r1_hash;
    logic [15:0] r1_phase;
    logic [39:0] r1_py;
    logic [15:0] r1_px;
    logic [31:0] hash_p;
    logic [45:0] py_p, px_p;
    logic signed [56:0] bx_p, by_p;
    logic signed [56:0] r_bx [BASE_D];
    logic signed [56:0] r_by [BASE_D];

    // stage 2
    logic [31:0] hx;
    logic [15:0] seed;
    logic [15:0] r2_seed, r2_a1, r2_a3;
    logic [39:0] r2_py;

    // stage 3
    logic [37:0] r3_mlo;
    logic [19:0] r3_mhi;
    logic [15:0] r3_sk, r3_a1, r3_a3;
    logic [37:0] mhi_full;
    logic [32:0] sk_full;

    // stage 4
    logic [39:0] a2_sum;
    logic [15:0] r4_a1, r4_a2, r4_a3;

    logic signed [15:0] s1, s2, s3;

    // stage 9
    logic signed [15:0] r9_s1;
    logic signed [33:0] r9_yprod, r9_xprod;
    logic signed [56:0] r9_bx, r9_by;

    // stage 10 and divider
    logic signed [33:0] num;
    logic [32:0]        r_dv_rem [DB+1];
    logic [15:0]        r_dv_q   [DB+1];
    logic               r_dv_neg [DB+1];
    logic [31:0]        r_dv_ox  [DB+1];
    logic signed [56:0] r_dv_by  [DB+1];

    // tail
    logic signed [16:0] r27_wy;
    logic [31:0]        r27_ox, r28_ox;
    logic signed [56:0] r27_by, r28_by;
    logic signed [34:0] r28_yprod;
    logic [31:0]        r_out_x, r_out_y;

    assign en          = !r_vld[DEPTH-1] || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign div_den     = puvf_pkg::ONE_Q16 + 18'(r_irregularity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude_x  <= '0;
            r_amplitude_y  <= '0;
            r_frequency_x  <= '0;
            r_frequency_y  <= '0;
            r_drift_x      <= '0;
            r_drift_y      <= '0;
            r_irregularity <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                puvf_pkg::REG_AMPLITUDE_X: r_amplitude_x  <= i_cfg_data[16:0];
                puvf_pkg::REG_AMPLITUDE_Y: r_amplitude_y  <= i_cfg_data[16:0];
                puvf_pkg::REG_FREQUENCY_X: r_frequency_x  <= i_cfg_data[13:0];
                puvf_pkg::REG_FREQUENCY_Y: r_frequency_y  <= i_cfg_data[13:0];
                puvf_pkg::REG_DRIFT_X:     r_drift_x      <= $signed(i_cfg_data);
                puvf_pkg::REG_DRIFT_Y:     r_drift_y      <= $signed(i_cfg_data);
                puvf_pkg::REG_IRREGULAR:   r_irregularity <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_comb begin
        hash_p   = i_particle_index * puvf_pkg::HASH_MULT;
        py_p     = i_time_q16 * r_frequency_y;
        px_p     = i_time_q16 * r_frequency_x;
        bx_p     = r_drift_x * $signed({1'b0, i_time_q16});
        by_p     = r_drift_y * $signed({1'b0, i_time_q16});
        hx       = r1_hash ^ (r1_hash >> 15);
        seed     = (r1_phase != 16'd0) ? r1_phase : hx[15:0];
        mhi_full = r2_py[39:20] * puvf_pkg::A2_TIME_K;
        sk_full  = r2_seed * puvf_pkg::A2_SEED_K;
        a2_sum   = 40'(r3_mlo) + {r3_mhi, 20'd0};
        num      = (34'(r9_s1) <<< 16) + r9_yprod;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_hash  <= hash_p;
            r1_phase <= i_phase_turns;
            r1_py    <= py_p[39:0];
            r1_px    <= px_p[23:8];
            r_bx[0]  <= bx_p;
            r_by[0]  <= by_p;
            for (int i = 1; i < BASE_D; i++) begin
                r_bx[i] <= r_bx[i-1];
                r_by[i] <= r_by[i-1];
            end

            r2_seed <= seed;
            r2_a1   <= r1_py[23:8] + seed;
            r2_a3   <= r1_px + {1'b0, seed[15:1]};
            r2_py   <= r1_py;

            r3_mlo <= r2_py[19:0] * puvf_pkg::A2_TIME_K;
            r3_mhi <= mhi_full[19:0];
            r3_sk  <= sk_full[31:16];
            r3_a1  <= r2_a1;
            r3_a3  <= r2_a3;

            r4_a2 <= a2_sum[39:24] + r3_sk;
            r4_a1 <= r3_a1;
            r4_a3 <= r3_a3;

            r9_s1    <= s1;
            r9_yprod <= $signed({1'b0, r_irregularity}) * s2;
            r9_xprod <= s3 * $signed({1'b0, r_amplitude_x});
            r9_bx    <= r_bx[BASE_D-1];
            r9_by    <= r_by[BASE_D-1];

            r_dv_neg[0] <= num[33];
            r_dv_rem[0] <= 33'(num[33] ? -num : num);
            r_dv_q[0]   <= '0;
            r_dv_ox[0]  <= puvf_pkg::sat_q16(58'(r9_bx) + (58'(r9_xprod) <<< 1));
            r_dv_by[0]  <= r9_by;

            r27_wy <= r_dv_neg[DB] ? -$signed({1'b0, r_dv_q[DB]})
                                   : $signed({1'b0, r_dv_q[DB]});
            r27_ox <= r_dv_ox[DB];
            r27_by <= r_dv_by[DB];

            r28_yprod <= r27_wy * $signed({1'b0, r_amplitude_y});
            r28_ox    <= r27_ox;
            r28_by    <= r27_by;

            r_out_x <= r28_ox;
            r_out_y <= puvf_pkg::sat_q16(58'(r28_by) + (58'(r28_yprod) <<< 1));
        end
    end

    puvf_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine_a1 (
        .i_clk(i_clk), .i_en(en), .i_angle(r4_a1), .o_sine(s1)
    );
    puvf_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine_a2 (
        .i_clk(i_clk), .i_en(en), .i_angle(r4_a2), .o_sine(s2)
    );
    puvf_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine_a3 (
        .i_clk(i_clk), .i_en(en), .i_angle(r4_a3), .o_sine(s3)
    );

    // restoring divide of the wobble numerator magnitude, one quotient bit per stage
    for (genvar k = 0; k < DB; k++) begin : g_div
        localparam int BIT = DB - 1 - k;
        logic [33:0] sub;
        logic        take;
        logic [15:0] n_q;
        always_comb begin
            sub      = 34'(div_den) << BIT;
            take     = ({1'b0, r_dv_rem[k]} >= sub);
            n_q      = r_dv_q[k];
            n_q[BIT] = take;
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k+1] <= take ? (r_dv_rem[k] - sub[32:0]) : r_dv_rem[k];
                r_dv_q[k+1]   <= n_q;
                r_dv_neg[k+1] <= r_dv_neg[k];
                r_dv_ox[k+1]  <= r_dv_ox[k];
                r_dv_by[k+1]  <= r_dv_by[k];
            end
        end
    end

    assign o_valid       = r_vld[DEPTH-1];
    assign o_uv_offset_x = $signed(r_out_x);
    assign o_uv_offset_y = $signed(r_out_y);

endmodule
